// ===== hw/rtl/lrd_pkg.sv =====
// Shared constants, command codes and handshake structs of the 48-bit LCG draw block.
`timescale 1ns / 1ps
`default_nettype none
package lrd_pkg;

  localparam int unsigned STATE_W = 48;
  localparam int unsigned SEED_W  = 32;
  localparam int unsigned VALUE_W = 53;
  localparam int unsigned BOUND_W = 31;
  localparam int unsigned BITS_W  = 6;
  localparam int unsigned CHUNK_W = 16;
  localparam int unsigned MULT_W  = 35;

  localparam logic [STATE_W-1:0] LCG_MULT = 48'h0005_DEEC_E66D;
  localparam logic [STATE_W-1:0] LCG_ADD  = 48'h0000_0000_000B;

  typedef enum logic [1:0] {
    CMD_RAW     = 2'd0,
    CMD_BOUNDED = 2'd1,
    CMD_WIDE    = 2'd2,
    CMD_RESEED  = 2'd3
  } cmd_t;

  // Requests from the sequencer to the state unit
  typedef struct packed {
    logic start;  // begin one state advance
    logic load;   // overwrite the state with load_state
  } lcg_ctrl_t;

  // Status from the state unit back to the sequencer
  typedef struct packed {
    logic busy;
    logic done;   // new state visible this cycle
  } lcg_stat_t;

  // Sign-extend the seed and xor in the multiplier
  function automatic logic [STATE_W-1:0] scramble(input logic [SEED_W-1:0] seed);
    logic [STATE_W-1:0] ext;
    ext = {{(STATE_W-SEED_W){seed[SEED_W-1]}}, seed};
    return ext ^ LCG_MULT;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/lcg48_random_draw.sv =====
// Top level of the 48-bit LCG random draw block: sequencer, divider and output register.
//
//  channel | dir | handshake            | content
//  in      | in  | in_tvalid/in_tready  | tuser: command; tdata: draw_bits, bound
//  out     | out | out_tvalid/out_tready| tdata: value
//  cfg     | in  | cfg_wr_en            | cfg_wr_data: seed_value
//
// A state advance runs in the three-slice multiply-accumulate unit. A wide draw
// takes two advances, a power-of-two bound a multiply-shift; a bounded draw with
// any other bound runs the 31-step restoring divider and repeats for each rejected
// draw. Reset loads the scrambled zero seed.
// in_tready is high only in idle; a result waiting at out holds the sequencer in
// its last state until the output register frees.
`timescale 1ns / 1ps
`default_nettype none
module lcg48_random_draw (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         cfg_wr_en,
  input  wire  [31:0] cfg_wr_data,   // seed_value
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [1:0]  in_tuser,      // command
  input  wire  [39:0] in_tdata,      // [5:0] draw_bits, [36:6] bound, [39:37] zero
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [55:0] out_tdata      // [52:0] value, [55:53] zero
);
  import lrd_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_DRAW = 6'b000010,
    ST_POW  = 6'b000100,
    ST_DIV  = 6'b001000,
    ST_CHK  = 6'b010000,
    ST_DONE = 6'b100000
  } state_t;

  state_t               st_r, st_nxt;
  logic [SEED_W-1:0]    seed_r;
  cmd_t                 cmd_r, cmd_nxt;
  logic [BITS_W-1:0]    bits_r, bits_nxt;
  logic [BOUND_W-1:0]   bound_r, bound_nxt;
  logic [BOUND_W-1:0]   u_r, u_nxt;
  logic [BOUND_W-1:0]   rem_r, rem_nxt;
  logic [4:0]           cnt_r, cnt_nxt;
  logic                 phase_r, phase_nxt;
  logic [VALUE_W-1:0]   res_r, res_nxt;
  logic                 out_vld_r, out_vld_nxt;
  logic [VALUE_W-1:0]   out_data_r, out_data_nxt;

  lcg_ctrl_t            lcg_ctrl;
  lcg_stat_t            lcg_stat;
  logic [STATE_W-1:0]   lcg_state;
  logic [STATE_W-1:0]   seed_scr;

  logic                 in_acc;
  cmd_t                 in_cmd;
  logic [BITS_W-1:0]    bits_eff;
  logic [BITS_W-1:0]    shamt;
  logic [31:0]          raw_val;
  logic                 pow2;
  logic [2*BOUND_W-1:0] pow_prod;
  logic [BOUND_W:0]     rem_sh;
  logic                 rem_ge;
  logic [31:0]          chk;

  lrd_lcg_step u_step (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (lcg_ctrl),
    .load_state (seed_scr),
    .stat       (lcg_stat),
    .state      (lcg_state)
  );

  assign seed_scr  = scramble(seed_r);
  assign in_tready = (st_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign in_cmd    = cmd_t'(in_tuser);

  // Saturate width at 32, then take the top bits of the fresh state
  assign bits_eff = (bits_r > 6'd32) ? 6'd32 : bits_r;
  assign shamt    = 6'd32 - bits_eff;
  assign raw_val  = (bits_eff == 6'd0) ? 32'd0 : (lcg_state[47:16] >> shamt);

  assign pow2     = ((bound_r & (bound_r - 31'd1)) == '0);
  assign pow_prod = {{BOUND_W{1'b0}}, bound_r} * {{BOUND_W{1'b0}}, u_r};

  assign rem_sh   = {rem_r, u_r[cnt_r]};
  assign rem_ge   = (rem_sh >= {1'b0, bound_r});
  // Rejection test: sign of (u - r + bound - 1) in 32-bit wrap
  assign chk      = {1'b0, u_r} - {1'b0, rem_r} + {1'b0, bound_r} - 32'd1;

  always_comb begin
    st_nxt         = st_r;
    cmd_nxt        = cmd_r;
    bits_nxt       = bits_r;
    bound_nxt      = bound_r;
    u_nxt          = u_r;
    rem_nxt        = rem_r;
    cnt_nxt        = cnt_r;
    phase_nxt      = phase_r;
    res_nxt        = res_r;
    out_vld_nxt    = out_vld_r;
    out_data_nxt   = out_data_r;
    lcg_ctrl.start = 1'b0;
    lcg_ctrl.load  = 1'b0;

    if (out_vld_r && out_tready) begin
      out_vld_nxt = 1'b0;
    end

    case (st_r)
      ST_IDLE: begin
        if (in_acc) begin
          cmd_nxt   = in_cmd;
          bits_nxt  = in_tdata[5:0];
          bound_nxt = in_tdata[36:6];
          phase_nxt = 1'b0;
          if (in_cmd == CMD_RESEED) begin
            lcg_ctrl.load = 1'b1;
            res_nxt       = '0;
            st_nxt        = ST_DONE;
          end else begin
            lcg_ctrl.start = 1'b1;
            st_nxt         = ST_DRAW;
          end
        end
      end
      ST_DRAW: begin
        if (lcg_stat.done) begin
          case (cmd_r)
            CMD_RAW: begin
              res_nxt = {21'd0, raw_val};
              st_nxt  = ST_DONE;
            end
            CMD_WIDE: begin
              if (!phase_r) begin
                res_nxt        = {lcg_state[47:22], 27'd0};
                phase_nxt      = 1'b1;
                lcg_ctrl.start = 1'b1;
              end else begin
                res_nxt = {res_r[52:27], lcg_state[47:21]};
                st_nxt  = ST_DONE;
              end
            end
            default: begin
              u_nxt   = lcg_state[47:17];
              rem_nxt = '0;
              cnt_nxt = 5'd30;
              st_nxt  = pow2 ? ST_POW : ST_DIV;
            end
          endcase
        end
      end
      ST_POW: begin
        res_nxt = {22'd0, pow_prod[2*BOUND_W-1:BOUND_W]};
        st_nxt  = ST_DONE;
      end
      ST_DIV: begin
        rem_nxt = rem_ge ? BOUND_W'(rem_sh - {1'b0, bound_r}) : rem_sh[BOUND_W-1:0];
        cnt_nxt = cnt_r - 5'd1;
        if (cnt_r == 5'd0) begin
          st_nxt = ST_CHK;
        end
      end
      ST_CHK: begin
        if (!chk[31]) begin
          res_nxt = {22'd0, rem_r};
          st_nxt  = ST_DONE;
        end else begin
          // drop this draw and try again
          lcg_ctrl.start = 1'b1;
          st_nxt         = ST_DRAW;
        end
      end
      ST_DONE: begin
        if (!out_vld_r || out_tready) begin
          out_vld_nxt  = 1'b1;
          out_data_nxt = res_r;
          st_nxt       = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= ST_IDLE;
      seed_r    <= '0;
      out_vld_r <= 1'b0;
      cmd_r     <= CMD_RAW;
      phase_r   <= 1'b0;
      cnt_r     <= '0;
    end else begin
      st_r      <= st_nxt;
      out_vld_r <= out_vld_nxt;
      cmd_r     <= cmd_nxt;
      phase_r   <= phase_nxt;
      cnt_r     <= cnt_nxt;
      if (cfg_wr_en) begin
        seed_r <= cfg_wr_data;
      end
    end
    bits_r     <= bits_nxt;
    bound_r    <= bound_nxt;
    u_r        <= u_nxt;
    rem_r      <= rem_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {3'd0, out_data_r};

  a_start_idle_unit: assert property (@(posedge clk) disable iff (!rst_n)
    lcg_ctrl.start |-> !lcg_stat.busy)
    else $error("state advance requested while unit busy");

  a_div_rem_below_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_DIV) |-> (rem_r < bound_r))
    else $error("divider remainder not below bound");

  a_reseed_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_cmd == CMD_RESEED) |=> (lcg_state == scramble($past(seed_r))))
    else $error("reseed did not load scrambled seed");

  a_bounded_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_CHK && !chk[31]) |=> (res_r < {22'd0, bound_r}))
    else $error("bounded draw out of range");

endmodule
`default_nettype wire

// ===== hw/rtl/lrd_lcg_step.sv =====
// LCG state register with a 16-bit-slice multiply-accumulate advance.
`timescale 1ns / 1ps
`default_nettype none
module lrd_lcg_step (
  input  wire                          clk,
  input  wire                          rst_n,
  input  lrd_pkg::lcg_ctrl_t           ctrl,
  input  wire [lrd_pkg::STATE_W-1:0]   load_state,
  output lrd_pkg::lcg_stat_t           stat,
  output logic [lrd_pkg::STATE_W-1:0]  state
);
  import lrd_pkg::*;

  logic [STATE_W-1:0]          state_r, state_nxt;
  logic [STATE_W-1:0]          acc_r, acc_nxt;
  logic [1:0]                  cnt_r, cnt_nxt;
  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;
  logic [CHUNK_W-1:0]          chunk;
  logic [CHUNK_W+MULT_W-1:0]   prod;
  logic [STATE_W-1:0]          prod_sh;

  always_comb begin
    case (cnt_r)
      2'd0:    chunk = state_r[15:0];
      2'd1:    chunk = state_r[31:16];
      default: chunk = state_r[47:32];
    endcase
  end

  assign prod = chunk * LCG_MULT[MULT_W-1:0];

  // Place the partial product at its slice weight, drop bits of weight 2^48 and above
  always_comb begin
    case (cnt_r)
      2'd0:    prod_sh = prod[STATE_W-1:0];
      2'd1:    prod_sh = {prod[STATE_W-CHUNK_W-1:0], {CHUNK_W{1'b0}}};
      default: prod_sh = {prod[STATE_W-2*CHUNK_W-1:0], {(2*CHUNK_W){1'b0}}};
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    acc_nxt   = acc_r;
    cnt_nxt   = cnt_r;
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    if (ctrl.load) begin
      state_nxt = load_state;
    end else if (ctrl.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 2'd0;
      acc_nxt  = '0;
    end else if (busy_r) begin
      acc_nxt = acc_r + prod_sh;
      cnt_nxt = cnt_r + 2'd1;
      if (cnt_r == 2'd2) begin
        state_nxt = acc_r + prod_sh + LCG_ADD;
        busy_nxt  = 1'b0;
        done_nxt  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= LCG_MULT;
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
      cnt_r   <= 2'd0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= busy_nxt;
      done_r  <= done_nxt;
      cnt_r   <= cnt_nxt;
    end
    acc_r <= acc_nxt;
  end

  assign state     = state_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule
`default_nettype wire

// ===== test/tb_lcg48_random_draw.sv =====
// Self-checking testbench for the 48-bit LCG random draw block with a transaction-level state predictor.
`timescale 1ns / 1ps
module tb_lcg48_random_draw;
  import lrd_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned HOLD_LEN    = 400;
  localparam int unsigned HOLD_AFTER  = 300;
  localparam int unsigned DRAIN_WAIT  = 200;
  localparam int unsigned PHASE_ITEMS = 290;
  localparam int unsigned MAX_REPORTS = 10;

  typedef struct {
    cmd_t        cmd;
    logic [5:0]  bits;
    logic [30:0] bound;
  } draw_req_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [31:0] cfg_wr_data = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [1:0]  in_tuser = '0;      // command
  logic [39:0] in_tdata = '0;      // [5:0] draw_bits, [36:6] bound, [39:37] zero
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;          // [52:0] value, [55:53] zero

  lcg48_random_draw u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tuser    (in_tuser),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Predictor state
  logic [47:0] gen_state;
  logic [31:0] gen_seed;

  draw_req_t   pend_q[$];
  logic [55:0] value_q[$];
  draw_req_t   cur_req;

  int unsigned in_gap = 0;
  int unsigned out_wait = 0;
  int unsigned gap_draw;
  int unsigned wait_draw;
  bit          no_idle = 1'b0;
  int unsigned err_cnt = 0;
  int unsigned checked_cnt = 0;
  int unsigned cmd_cnt[4] = '{0, 0, 0, 0};
  int unsigned cycle_cnt = 0;

  logic        hold_active = 1'b0;
  logic        hold_done = 1'b0;
  int unsigned hold_left = 0;
  int unsigned seen_cnt = 0;

  function automatic logic [47:0] seed_scramble(input logic [31:0] seed);
    return {{16{seed[31]}}, seed} ^ LCG_MULT;
  endfunction

  // Advance the state once and return its top n bits (n saturates at 32)
  function automatic logic [31:0] advance_top(input int unsigned n);
    gen_state = gen_state * LCG_MULT + LCG_ADD;
    if (n == 0) return 32'd0;
    if (n > 32) n = 32;
    return 32'(gen_state >> (48 - n));
  endfunction

  function automatic logic [52:0] bounded_draw(input logic [30:0] bnd);
    logic [31:0] b;
    logic [31:0] m;
    logic [31:0] r;
    logic [31:0] u;
    logic [63:0] prod;
    logic [52:0] res;
    bit          done;
    b = {1'b0, bnd};
    m = b - 32'd1;
    r = advance_top(31);
    res = '0;
    done = 1'b0;
    // power of two, zero included: multiply-shift
    if ((b & m) == 32'd0) begin
      prod = {32'd0, b} * {32'd0, r};
      return 53'(prod >> 31);
    end
    while (!done) begin
      u = r;
      r = u % b;
      if (((u - r + m) & 32'h8000_0000) == 32'd0) begin
        res = 53'(r);
        done = 1'b1;
      end else begin
        r = advance_top(31);
      end
    end
    return res;
  endfunction

  function automatic logic [55:0] predict_value(input draw_req_t rq);
    logic [52:0] v;
    logic [31:0] hi;
    logic [31:0] lo;
    v = '0;
    case (rq.cmd)
      CMD_RAW: begin
        v = 53'(advance_top(rq.bits));
      end
      CMD_BOUNDED: begin
        v = bounded_draw(rq.bound);
      end
      CMD_WIDE: begin
        hi = advance_top(26);
        lo = advance_top(27);
        v = (53'(hi) << 27) + 53'(lo);
      end
      default: begin
        gen_state = seed_scramble(gen_seed);
      end
    endcase
    return {3'b000, v};
  endfunction

  function automatic draw_req_t make_req(input cmd_t c, input logic [5:0] b,
                                         input logic [30:0] bd);
    draw_req_t rq;
    rq.cmd = c;
    rq.bits = b;
    rq.bound = bd;
    return rq;
  endfunction

  function automatic draw_req_t random_req();
    draw_req_t   rq;
    int unsigned k;
    k = $urandom_range(0, 99);
    if (k < 35) rq.cmd = CMD_RAW;
    else if (k < 70) rq.cmd = CMD_BOUNDED;
    else if (k < 90) rq.cmd = CMD_WIDE;
    else rq.cmd = CMD_RESEED;
    k = $urandom_range(0, 9);
    if (k == 0) rq.bits = 6'($urandom_range(0, 63));
    else rq.bits = 6'($urandom_range(1, 32));
    k = $urandom_range(0, 9);
    case (k)
      0, 1, 2: rq.bound = 31'($urandom_range(1, 100));
      3, 4:    rq.bound = 31'(1) << $urandom_range(0, 30);
      5, 6:    rq.bound = 31'($urandom);
      7:       rq.bound = 31'($urandom_range(32'h4000_0000, 32'h7FFF_FFFF));
      8:       rq.bound = 31'h7FFF_FFFF - 31'($urandom_range(0, 15));
      default: rq.bound = 31'($urandom_range(0, 3));
    endcase
    return rq;
  endfunction

  // Sender: present queued words with random gaps, none while no_idle is set
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_gap <= 0;
    end else if (in_tvalid && in_tready) begin
      value_q.push_back(predict_value(cur_req));
      cmd_cnt[cur_req.cmd] = cmd_cnt[cur_req.cmd] + 1;
      gap_draw = no_idle ? 0 : $urandom_range(0, 4);
      if (gap_draw == 0 && pend_q.size() > 0) begin
        cur_req = pend_q.pop_front();
        in_tuser <= cur_req.cmd;
        in_tdata <= {3'b000, cur_req.bound, cur_req.bits};
      end else begin
        in_tvalid <= 1'b0;
        in_gap <= gap_draw;
      end
    end else if (!in_tvalid) begin
      if (in_gap != 0) begin
        in_gap <= in_gap - 1;
      end else if (pend_q.size() > 0) begin
        cur_req = pend_q.pop_front();
        in_tvalid <= 1'b1;
        in_tuser <= cur_req.cmd;
        in_tdata <= {3'b000, cur_req.bound, cur_req.bits};
      end
    end
  end

  // Long receiver hold-off once, while the sender keeps offering
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_active <= 1'b0;
      hold_done <= 1'b0;
      hold_left <= 0;
      seen_cnt <= 0;
    end else begin
      if (in_tvalid && in_tready) seen_cnt <= seen_cnt + 1;
      if (!hold_done && seen_cnt >= HOLD_AFTER) begin
        hold_active <= 1'b1;
        hold_done <= 1'b1;
        hold_left <= HOLD_LEN;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        if (hold_left == 1) hold_active <= 1'b0;
      end
    end
  end

  // Receiver: check each word against the oldest prediction
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_wait <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        checked_cnt = checked_cnt + 1;
        if (value_q.size() == 0) begin
          err_cnt = err_cnt + 1;
          if (err_cnt <= MAX_REPORTS)
            $display("mismatch: unexpected word %h", out_tdata);
        end else if (out_tdata !== value_q[0]) begin
          err_cnt = err_cnt + 1;
          if (err_cnt <= MAX_REPORTS)
            $display("mismatch on word %0d: expected %h, got %h",
                     checked_cnt, value_q[0], out_tdata);
          void'(value_q.pop_front());
        end else begin
          void'(value_q.pop_front());
        end
        wait_draw = no_idle ? 0 : $urandom_range(0, 4);
        out_wait <= wait_draw;
        out_tready <= (wait_draw == 0) && !hold_active;
      end else if (out_wait != 0) begin
        out_wait <= out_wait - 1;
        out_tready <= (out_wait == 1) && !hold_active;
      end else begin
        out_tready <= !hold_active;
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt = cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycle_cnt, value_q.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  logic [31:0] seed_list[6];

  task automatic wait_idle();
    @(negedge clk);
    while (pend_q.size() != 0 || in_tvalid || value_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_seed(input logic [31:0] s);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= s;
    gen_seed = s;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= $urandom;
    @(negedge clk);
  endtask

  initial begin
    gen_seed = 32'd0;
    gen_state = seed_scramble(32'd0);
    seed_list[0] = 32'd0;
    seed_list[1] = 32'h8000_0000;
    seed_list[2] = 32'h7FFF_FFFF;
    seed_list[3] = 32'hFFFF_FFFF;
    seed_list[4] = $urandom;
    seed_list[5] = $urandom;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // First draws straight out of reset use the scrambled zero seed
    @(negedge clk);
    pend_q.push_back(make_req(CMD_RAW, 6'd32, 31'($urandom)));
    pend_q.push_back(make_req(CMD_RAW, 6'd0, 31'h7FFF_FFFF));
    pend_q.push_back(make_req(CMD_RAW, 6'd1, 31'd0));
    pend_q.push_back(make_req(CMD_RAW, 6'd24, 31'($urandom)));
    pend_q.push_back(make_req(CMD_RAW, 6'd31, 31'($urandom)));
    pend_q.push_back(make_req(CMD_RAW, 6'd33, 31'($urandom)));
    pend_q.push_back(make_req(CMD_RAW, 6'd63, 31'h7FFF_FFFF));
    pend_q.push_back(make_req(CMD_BOUNDED, 6'd0, 31'd0));
    pend_q.push_back(make_req(CMD_BOUNDED, 6'd63, 31'd1));
    pend_q.push_back(make_req(CMD_BOUNDED, 6'($urandom), 31'd2));
    pend_q.push_back(make_req(CMD_BOUNDED, 6'($urandom), 31'h4000_0000));
    pend_q.push_back(make_req(CMD_BOUNDED, 6'($urandom), 31'd3));
    pend_q.push_back(make_req(CMD_BOUNDED, 6'($urandom), 31'd100));
    pend_q.push_back(make_req(CMD_BOUNDED, 6'($urandom), 31'h7FFF_FFFF));
    pend_q.push_back(make_req(CMD_BOUNDED, 6'($urandom), 31'h4000_0001));
    pend_q.push_back(make_req(CMD_BOUNDED, 6'($urandom), 31'h5555_5555));
    pend_q.push_back(make_req(CMD_WIDE, 6'($urandom), 31'($urandom)));
    pend_q.push_back(make_req(CMD_WIDE, 6'h3F, 31'h7FFF_FFFF));
    pend_q.push_back(make_req(CMD_RESEED, 6'($urandom), 31'($urandom)));
    pend_q.push_back(make_req(CMD_RAW, 6'd32, 31'($urandom)));
    wait_idle();

    // Random phases, one seed setting each; one phase runs without gaps
    for (int p = 0; p < 6; p++) begin
      write_seed(seed_list[p]);
      no_idle = (p == 3);
      pend_q.push_back(make_req(CMD_RESEED, 6'($urandom), 31'($urandom)));
      for (int i = 0; i < PHASE_ITEMS - 60; i++) pend_q.push_back(random_req());
      wait_idle();
    end

    no_idle = 1'b0;
    repeat (DRAIN_WAIT) @(posedge clk);
    @(negedge clk);
    err_cnt = err_cnt + value_q.size();
    $display("checked %0d words: %0d raw, %0d bounded, %0d wide, %0d reseed",
             checked_cnt, cmd_cnt[CMD_RAW], cmd_cnt[CMD_BOUNDED], cmd_cnt[CMD_WIDE],
             cmd_cnt[CMD_RESEED]);
    $display("seed settings: reset default plus 6 written, one long output hold-off");
    if (err_cnt == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
